>>> rtl/load_file_header_crc_checker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the load file header CRC checker
// Shared concurrent checks, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LOAD_FILE_HEADER_CRC_CHECKER_DEFINES_SVH
`define LOAD_FILE_HEADER_CRC_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define LFHCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LFHCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lfhcc_pkg.sv
// ----------------------------------------------------------------------------
// lfhcc_pkg
// Types, codes and the bytewise CRC-16 step for the load file checker.
// ----------------------------------------------------------------------------
package lfhcc_pkg;

    localparam int COUNT_WIDTH_DEF = 34;
    localparam int RING_AW         = 16;
    localparam int RING_DEPTH      = 1 << RING_AW;

    // header layout and size limits
    localparam int LEN_BYTES  = 4;
    localparam int VER_END    = 6;
    localparam int MIN_BYTES  = 8;
    localparam int CRC_BYTES  = 2;

    // register indexes
    localparam logic [2:0] REG_POLY    = 3'd0;
    localparam logic [2:0] REG_INIT    = 3'd1;
    localparam logic [2:0] REG_XOR     = 3'd2;
    localparam logic [2:0] REG_VERSION = 3'd3;
    localparam logic [2:0] REG_OFFSET  = 3'd4;
    localparam logic [2:0] REG_MINSIZE = 3'd5;

    // status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_TOO_SMALL = 3'd1;
    localparam logic [2:0] STATUS_SIZE      = 3'd2;
    localparam logic [2:0] STATUS_VERSION   = 3'd3;
    localparam logic [2:0] STATUS_BAD_CRC   = 3'd4;

    // register reset values
    localparam logic [15:0] POLY_RST    = 16'h1021;
    localparam logic [15:0] INIT_RST    = 16'hFFFF;
    localparam logic [15:0] XOR_RST     = 16'h0000;
    localparam logic [15:0] VERSION_RST = 16'h0000;
    localparam logic [15:0] OFFSET_RST  = 16'd2;
    localparam logic [7:0]  MINSIZE_RST = 8'd8;

    typedef struct packed {
        logic [15:0] poly;
        logic [15:0] init;
        logic [15:0] final_xor;
        logic [15:0] version;
        logic [15:0] offset;
        logic [7:0]  min_bytes;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] length_words;
        logic [15:0] version;
        logic [15:0] stored_crc;
        logic [15:0] computed_crc;
    } res_t;

    // Non-reflected CRC-16, MSB first, one byte.
    function automatic logic [15:0] crc16_byte(
        input logic [15:0] crc,
        input logic [7:0]  data,
        input logic [15:0] poly
    );
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/load_file_header_crc_checker.sv
// ----------------------------------------------------------------------------
// load_file_header_crc_checker
// Streams a load file byte by byte, captures its header, runs CRC-16 over
// the covered bytes and gives one status item on the last byte.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  --------------------------
//  data      in         data_valid / data_stall   data_byte, last_byte
//  result    out        result_valid / result_st  status, file_length_words,
//                                                 format_version, stored_crc,
//                                                 computed_crc
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  One byte per cycle sustained while data_stall is low. A byte is registered
//  into stage 1 with its ring lookahead read when it is taken, and processed
//  when stage 1 fires; a last byte's result item is then registered into the
//  output register, which drives result_valid.
//  The 64 KiB ring memory has one write and one read port, used once per item.
//  data_stall rises only when a last byte waits behind an untaken result.
//  Reset clears control and config state; the ring needs no clearing pass.
//  cfg_ready is always high; writes are registered.
//
module load_file_header_crc_checker #(
    parameter int COUNT_WIDTH = lfhcc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte stream
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // result
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [31:0] file_length_words,
    output logic [15:0] format_version,
    output logic [15:0] stored_crc,
    output logic [15:0] computed_crc,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lfhcc_pkg::*;

    `include "load_file_header_crc_checker_defines.svh"

    cfg_t cfg;
    res_t res;

    logic       accept;
    logic       fire;
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic [7:0] ring_byte;
    logic       out_valid_reg, out_valid_next;
    res_t       out_reg;

    assign cfg_ready = 1'b1;

    lfhcc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // ring write and lookahead read happen at accept, aligned with stage 1
    lfhcc_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_last (last_byte),
        .wr_byte (data_byte),
        .offset  (cfg.offset),
        .rd_byte (ring_byte)
    );

    lfhcc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data      (s1_byte_reg),
        .last      (s1_last_reg),
        .ring_byte (ring_byte),
        .cfg       (cfg),
        .res       (res)
    );

    // Stage 1 drains every cycle unless a last byte meets a stalled output reg.
    assign fire       = s1_valid_reg & (~s1_last_reg | ~out_valid_reg | ~result_stall);
    assign data_stall = s1_valid_reg & ~fire;
    assign accept     = data_valid & ~data_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && s1_last_reg)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (fire && s1_last_reg)
            out_reg <= res;
    end

    assign result_valid      = out_valid_reg;
    assign status            = out_reg.status;
    assign file_length_words = out_reg.length_words;
    assign format_version    = out_reg.version;
    assign stored_crc        = out_reg.stored_crc;
    assign computed_crc      = out_reg.computed_crc;

    `LFHCC_ASSERT_IMP(a_status_range, out_valid_reg, out_reg.status <= STATUS_BAD_CRC,
        "status code out of range")
    `LFHCC_ASSERT_IMP(a_stall_cause, data_stall,
        s1_valid_reg && s1_last_reg && out_valid_reg && result_stall,
        "input stalled without a blocked last byte")
    `LFHCC_ASSERT_NXT(a_result_drains,
        out_valid_reg && !result_stall && !(fire && s1_last_reg), !out_valid_reg,
        "taken result item not retired")
    `LFHCC_ASSERT_IMP(a_ok_means_match, out_valid_reg && out_reg.status == STATUS_OK,
        out_reg.stored_crc == out_reg.computed_crc,
        "ok status with differing checksums")

endmodule

>>> rtl/lfhcc_cfg.sv
// ----------------------------------------------------------------------------
// lfhcc_cfg
// Configuration register bank; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lfhcc_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [2:0]       wr_index,
    input  logic [15:0]      wr_data,
    output lfhcc_pkg::cfg_t  cfg
);
    import lfhcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_POLY:    cfg_next.poly      = wr_data;
                REG_INIT:    cfg_next.init      = wr_data;
                REG_XOR:     cfg_next.final_xor = wr_data;
                REG_VERSION: cfg_next.version   = wr_data;
                REG_OFFSET:  cfg_next.offset    = wr_data;
                REG_MINSIZE: cfg_next.min_bytes = wr_data[7:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly      <= POLY_RST;
            cfg_reg.init      <= INIT_RST;
            cfg_reg.final_xor <= XOR_RST;
            cfg_reg.version   <= VERSION_RST;
            cfg_reg.offset    <= OFFSET_RST;
            cfg_reg.min_bytes <= MINSIZE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/lfhcc_ring.sv
// ----------------------------------------------------------------------------
// lfhcc_ring
// 64 KiB byte delay ring; one write and one lookahead read per item.
// ----------------------------------------------------------------------------
module lfhcc_ring (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic        wr_last,
    input  logic [7:0]  wr_byte,
    input  logic [15:0] offset,
    output logic [7:0]  rd_byte
);
    import lfhcc_pkg::*;

    logic [7:0]         mem [RING_DEPTH];
    logic [RING_AW-1:0] wp_reg;
    logic [RING_AW-1:0] wp_next;
    logic [RING_AW-1:0] rd_addr;
    logic [7:0]         rd_reg;

    // read two bytes ahead of the CRC tap: position wp - offset + 2
    assign rd_addr = wp_reg - offset[RING_AW-1:0] + RING_AW'(CRC_BYTES);
    assign wp_next = wr_last ? '0 : wp_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wp_reg <= '0;
        else if (wr_en)
            wp_reg <= wp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_byte;
            rd_reg      <= mem[rd_addr];
        end
    end

    assign rd_byte = rd_reg;

endmodule

>>> rtl/lfhcc_core.sv
// ----------------------------------------------------------------------------
// lfhcc_core
// Per-file state: byte count, CRC, header fields, and the result compute.
// ----------------------------------------------------------------------------
module lfhcc_core #(
    parameter int COUNT_WIDTH = lfhcc_pkg::COUNT_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       data,
    input  logic             last,
    input  logic [7:0]       ring_byte,
    input  lfhcc_pkg::cfg_t  cfg,
    output lfhcc_pkg::res_t  res
);
    import lfhcc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 33) ? COUNT_WIDTH : 33;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [15:0]            crc_reg;
    logic [31:0]            len_reg;
    logic [15:0]            ver_reg;
    logic [7:0]             la_d1_reg, la_d2_reg, prev_reg;

    logic [7:0]       la_byte;
    logic [7:0]       feed_byte;
    logic [15:0]      crc_base, crc_new;
    logic [31:0]      len_now;
    logic [15:0]      ver_now;
    logic [CMP_W-1:0] n_ext, offs_ext, len2_ext;
    logic             offs_ok;
    logic [15:0]      stored;
    logic [15:0]      computed;

    // with offset 2 the lookahead byte is the one arriving now
    assign la_byte = (cfg.offset == 16'(CRC_BYTES)) ? data : ring_byte;

    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign crc_base   = (count_reg == '0) ? cfg.init : crc_reg;

    assign n_ext    = CMP_W'(count_next);
    assign offs_ext = CMP_W'(cfg.offset);

    always_comb
    begin
        case (cfg.offset)
            16'd0:   feed_byte = data;
            16'd1:   feed_byte = prev_reg;
            default: feed_byte = la_d2_reg;
        endcase
    end

    assign crc_new = (n_ext > offs_ext) ? crc16_byte(crc_base, feed_byte, cfg.poly)
                                        : crc_base;

    // header capture, big-endian
    always_comb
    begin
        len_now = len_reg;
        ver_now = ver_reg;
        if (count_reg < COUNT_WIDTH'(LEN_BYTES))
        begin
            case (count_reg[1:0])
                2'd0:    len_now[31:24] = data;
                2'd1:    len_now[23:16] = data;
                2'd2:    len_now[15:8]  = data;
                default: len_now[7:0]   = data;
            endcase
        end
        else if (count_reg < COUNT_WIDTH'(VER_END))
        begin
            if (count_reg[0])
                ver_now[7:0] = data;
            else
                ver_now[15:8] = data;
        end
    end

    assign len2_ext = CMP_W'({len_now, 1'b0});
    assign offs_ok  = (cfg.offset >= 16'(CRC_BYTES)) && (offs_ext <= n_ext);
    assign stored   = offs_ok ? {la_d1_reg, la_byte} : 16'h0000;
    assign computed = crc_new ^ cfg.final_xor;

    always_comb
    begin
        res.length_words = len_now;
        res.version      = ver_now;
        res.stored_crc   = stored;
        res.computed_crc = computed;
        if ((n_ext <= CMP_W'(cfg.min_bytes)) || (n_ext < CMP_W'(MIN_BYTES)) || !offs_ok)
            res.status = STATUS_TOO_SMALL;
        else if (len2_ext != n_ext)
            res.status = STATUS_SIZE;
        else if (ver_now != cfg.version)
            res.status = STATUS_VERSION;
        else if (stored != computed)
            res.status = STATUS_BAD_CRC;
        else
            res.status = STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= INIT_RST;
            len_reg   <= '0;
            ver_reg   <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                count_reg <= '0;
                len_reg   <= '0;
                ver_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                len_reg   <= len_now;
                ver_reg   <= ver_now;
            end
            crc_reg <= crc_new;
        end
    end

    // lookahead history: d1 is one item back, d2 two items back
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            la_d1_reg <= la_byte;
            la_d2_reg <= la_d1_reg;
            prev_reg  <= data;
        end
    end

endmodule
